>>> src/line_follower_drive_controller_core_defines.svh
// ============================================================================
// Line follower drive controller assertion macros
// Shared concurrent assertion forms for the drive controller core.
// ============================================================================
`ifndef LINE_FOLLOWER_DRIVE_CONTROLLER_CORE_DEFINES_SVH
`define LINE_FOLLOWER_DRIVE_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LFDC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfdc assertion failed");

// Next-cycle implication, disabled during reset.
`define LFDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfdc assertion failed");

`endif

>>> src/lfdc_pkg.sv
// ============================================================================
// Line follower drive controller package
// Types, command codes, register indexes and speed scaling tables.
// ============================================================================
package lfdc_pkg;

    localparam int TIME_BITS = 32;

    // Character codes
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7A;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_B  = 8'h42;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_F  = 8'h46;
    localparam logic [7:0] CH_L  = 8'h4C;
    localparam logic [7:0] CH_R  = 8'h52;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_X  = 8'h58;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [9:0] NO_ECHO_CM    = 10'd999;
    localparam logic [3:0] LEVEL_SLOWEST = 4'd10;
    localparam logic [3:0] LEVEL_FASTEST = 4'd1;
    localparam logic [3:0] LEVEL_RESET   = 4'd5;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_AVOID_DIST  = 3'd0,
        CFG_CHECK_PER   = 3'd1,
        CFG_BACK_TIME   = 3'd2,
        CFG_SPIN_TIME   = 3'd3,
        CFG_FWD_TIME    = 3'd4
    } cfg_idx_t;

    localparam logic [9:0]  AVOID_DIST_RST = 10'd16;
    localparam logic [15:0] CHECK_PER_RST  = 16'd80;
    localparam logic [15:0] BACK_TIME_RST  = 16'd600;
    localparam logic [15:0] SPIN_TIME_RST  = 16'd700;
    localparam logic [15:0] FWD_TIME_RST   = 16'd1200;

    // Avoidance phases
    localparam logic [1:0] PH_STOP = 2'd0;
    localparam logic [1:0] PH_BACK = 2'd1;
    localparam logic [1:0] PH_SPIN = 2'd2;
    localparam logic [1:0] PH_FWD  = 2'd3;

    // Base drive magnitudes
    typedef enum logic [1:0] {
        MAG_0   = 2'd0,
        MAG_70  = 2'd1,
        MAG_125 = 2'd2,
        MAG_150 = 2'd3
    } mag_t;

    typedef struct packed {
        logic l_neg;
        mag_t l_mag;
        logic r_neg;
        mag_t r_mag;
    } drive_t;

    localparam drive_t DRV_STOP   = '{1'b0, MAG_0,   1'b0, MAG_0};
    localparam drive_t DRV_FWD    = '{1'b0, MAG_150, 1'b0, MAG_150};
    localparam drive_t DRV_BACK   = '{1'b1, MAG_150, 1'b1, MAG_150};
    localparam drive_t DRV_SPIN_L = '{1'b1, MAG_150, 1'b0, MAG_150};
    localparam drive_t DRV_SPIN_R = '{1'b0, MAG_150, 1'b1, MAG_150};
    localparam drive_t DRV_SOFT_L = '{1'b0, MAG_70,  1'b0, MAG_125};
    localparam drive_t DRV_SOFT_R = '{1'b0, MAG_125, 1'b0, MAG_70};

    // Controller to datapath commands
    typedef struct packed {
        logic cap;
        logic exec;
        logic act;
        logic write;
    } ctl_t;

    // Scaled magnitudes per speed level, level 1 first
    localparam logic [7:0] SCALE_150 [10] = '{
        8'd255, 8'd235, 8'd214, 8'd194, 8'd173,
        8'd153, 8'd132, 8'd112, 8'd91,  8'd70
    };
    localparam logic [7:0] SCALE_125 [10] = '{
        8'd212, 8'd195, 8'd178, 8'd161, 8'd144,
        8'd127, 8'd110, 8'd93,  8'd75,  8'd58
    };
    localparam logic [7:0] SCALE_70 [10] = '{
        8'd119, 8'd109, 8'd99,  8'd90,  8'd80,
        8'd71,  8'd61,  8'd52,  8'd42,  8'd32
    };

    function automatic logic [7:0] scale_mag(input logic [3:0] level, input mag_t mag);
        logic [3:0] idx;
        logic [7:0] res;
        if (level < LEVEL_FASTEST) begin
            idx = 4'd0;
        end else if (level > LEVEL_SLOWEST) begin
            idx = LEVEL_SLOWEST - 4'd1;
        end else begin
            idx = level - 4'd1;
        end
        case (mag)
            MAG_70:  res = SCALE_70[idx];
            MAG_125: res = SCALE_125[idx];
            MAG_150: res = SCALE_150[idx];
            default: res = 8'd0;
        endcase
        return res;
    endfunction

    function automatic logic signed [8:0] to_drive(input logic neg, input logic [7:0] mag);
        logic signed [8:0] v;
        v = signed'({1'b0, mag});
        return neg ? -v : v;
    endfunction

endpackage

>>> src/line_follower_drive_controller_core.sv
// ============================================================================
// Line follower drive controller core
// Decodes commands, runs manual, tracking or avoidance drive, scales by speed.
// ============================================================================
// Sequence: an accepted input passes through execute, action and
//   write-back before the result is valid; write-back waits while a
//   previous result is stalled, and no new input is taken until idle.
// Reset: asynchronous, active low; mode, level, timers and holds return to
//   their start values and configuration registers to their defaults.
module line_follower_drive_controller_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              has_command,
    input  logic [7:0]        command_byte,
    input  logic [31:0]       now_ms,
    input  logic [3:0]        line_sensors,
    input  logic [9:0]        distance_cm,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [8:0] left_drive,
    output logic signed [8:0] right_drive,
    output logic              drive_updated,
    output logic              auto_mode,
    output logic [3:0]        speed_level
);

    `include "line_follower_drive_controller_core_defines.svh"

    lfdc_pkg::ctl_t ctl;

    lfdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    lfdc_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .has_command   (has_command),
        .command_byte  (command_byte),
        .now_ms        (now_ms),
        .line_sensors  (line_sensors),
        .distance_cm   (distance_cm),
        .left_drive    (left_drive),
        .right_drive   (right_drive),
        .drive_updated (drive_updated),
        .auto_mode     (auto_mode),
        .speed_level   (speed_level)
    );

    `LFDC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `LFDC_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, ctl.write, !(out_valid && out_stall))
    `LFDC_ASSERT_IMPLY(a_level_range, clk, rst_n, out_valid, speed_level >= 4'd1 && speed_level <= 4'd10)

endmodule

>>> src/lfdc_ctrl.sv
// ============================================================================
// Line follower drive controller sequencer
// Steps each item through execute, action and write-back, owns the handshake.
// ============================================================================
module lfdc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output lfdc_pkg::ctl_t ctl
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_ACT   = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_busy;

    assign out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.cap    = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                ctl.act    = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold until the previous result is taken
                if (!out_busy)
                begin
                    ctl.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.write)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> src/lfdc_dpath.sv
// ============================================================================
// Line follower drive controller datapath
// Holds configuration, mode, timing and drive state; decodes and scales.
// ============================================================================
module lfdc_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  lfdc_pkg::ctl_t      ctl,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                has_command,
    input  logic [7:0]          command_byte,
    input  logic [31:0]         now_ms,
    input  logic [3:0]          line_sensors,
    input  logic [9:0]          distance_cm,
    output logic signed [8:0]   left_drive,
    output logic signed [8:0]   right_drive,
    output logic                drive_updated,
    output logic                auto_mode,
    output logic [3:0]          speed_level
);

    localparam int TB = lfdc_pkg::TIME_BITS;

    // Configuration
    logic [9:0]  avoid_dist_reg;
    logic [15:0] check_per_reg;
    logic [15:0] back_time_reg;
    logic [15:0] spin_time_reg;
    logic [15:0] fwd_time_reg;

    // Captured item
    logic          has_reg;
    logic [7:0]    cmd_reg;
    logic [TB-1:0] now_reg;
    logic [3:0]    sens_reg;
    logic [9:0]    dist_reg;

    // Persistent state
    logic [3:0]        level_reg, level_next;
    logic              auto_reg, auto_next;
    logic [7:0]        manual_reg, manual_next;
    logic [TB-1:0]     last_check_reg, last_check_next;
    logic [1:0]        phase_reg, phase_next;
    logic [TB-1:0]     avoid_start_reg, avoid_start_next;
    logic signed [8:0] left_hold_reg, left_hold_next;
    logic signed [8:0] right_hold_reg, right_hold_next;

    // Per-item working state
    logic              skip_reg, skip_next;
    logic              upd_reg, upd_next;
    logic              due_reg, due_next;
    logic              done_reg, done_next;
    logic              drv_en_reg, drv_en_next;
    lfdc_pkg::drive_t  drv_reg, drv_next;

    // Result
    logic signed [8:0] left_out_reg;
    logic signed [8:0] right_out_reg;
    logic              upd_out_reg;
    logic              auto_out_reg;
    logic [3:0]        level_out_reg;

    logic [7:0]        up_cmd;
    logic [TB-1:0]     check_elapsed;
    logic [TB-1:0]     avoid_elapsed;
    logic [15:0]       phase_time;
    logic              obstacle;
    logic signed [8:0] left_new;
    logic signed [8:0] right_new;

    assign up_cmd = (cmd_reg >= lfdc_pkg::CH_LA && cmd_reg <= lfdc_pkg::CH_LZ)
                  ? cmd_reg - lfdc_pkg::CASE_OFFSET : cmd_reg;

    assign check_elapsed = now_reg - last_check_reg;
    assign avoid_elapsed = now_reg - avoid_start_reg;

    always_comb
    begin
        case (phase_reg)
            lfdc_pkg::PH_BACK: phase_time = back_time_reg;
            lfdc_pkg::PH_SPIN: phase_time = spin_time_reg;
            lfdc_pkg::PH_FWD:  phase_time = fwd_time_reg;
            default:           phase_time = '0;
        endcase
    end

    assign obstacle = (dist_reg < avoid_dist_reg) && (dist_reg != '0)
                   && (dist_reg != lfdc_pkg::NO_ECHO_CM);

    assign left_new  = lfdc_pkg::to_drive(drv_reg.l_neg,
                                          lfdc_pkg::scale_mag(level_reg, drv_reg.l_mag));
    assign right_new = lfdc_pkg::to_drive(drv_reg.r_neg,
                                          lfdc_pkg::scale_mag(level_reg, drv_reg.r_mag));

    always_comb
    begin
        level_next       = level_reg;
        auto_next        = auto_reg;
        manual_next      = manual_reg;
        last_check_next  = last_check_reg;
        phase_next       = phase_reg;
        avoid_start_next = avoid_start_reg;
        left_hold_next   = left_hold_reg;
        right_hold_next  = right_hold_reg;
        skip_next        = skip_reg;
        upd_next         = upd_reg;
        due_next         = due_reg;
        done_next        = done_reg;
        drv_en_next      = drv_en_reg;
        drv_next         = drv_reg;

        if (ctl.exec)
        begin
            skip_next = 1'b0;
            upd_next  = 1'b0;
            due_next  = check_elapsed > TB'(check_per_reg);
            done_next = avoid_elapsed >= TB'(phase_time);
            if (has_reg)
            begin
                if (cmd_reg == lfdc_pkg::CH_LF || cmd_reg == lfdc_pkg::CH_CR)
                begin
                    skip_next = 1'b1;
                end
                else if (cmd_reg >= lfdc_pkg::CH_1 && cmd_reg <= lfdc_pkg::CH_9)
                begin
                    level_next = cmd_reg[3:0];
                end
                else if (cmd_reg == lfdc_pkg::CH_0)
                begin
                    level_next = lfdc_pkg::LEVEL_SLOWEST;
                end
                else
                begin
                    manual_next = up_cmd;
                    if (up_cmd == lfdc_pkg::CH_X)
                    begin
                        auto_next       = !auto_reg;
                        left_hold_next  = '0;
                        right_hold_next = '0;
                        upd_next        = 1'b1;
                    end
                    else
                    begin
                        auto_next = 1'b0;
                    end
                end
            end
        end

        if (ctl.act)
        begin
            drv_en_next = 1'b0;
            drv_next    = lfdc_pkg::DRV_STOP;
            if (!skip_reg)
            begin
                if (!auto_reg)
                begin
                    drv_en_next = 1'b1;
                    upd_next    = 1'b1;
                    case (manual_reg)
                        lfdc_pkg::CH_F: drv_next = lfdc_pkg::DRV_FWD;
                        lfdc_pkg::CH_B: drv_next = lfdc_pkg::DRV_BACK;
                        lfdc_pkg::CH_L: drv_next = lfdc_pkg::DRV_SPIN_L;
                        lfdc_pkg::CH_R: drv_next = lfdc_pkg::DRV_SPIN_R;
                        lfdc_pkg::CH_A: drv_next = lfdc_pkg::DRV_SOFT_L;
                        lfdc_pkg::CH_D: drv_next = lfdc_pkg::DRV_SOFT_R;
                        default:        drv_next = lfdc_pkg::DRV_STOP;
                    endcase
                end
                else if (due_reg)
                begin
                    drv_en_next     = 1'b1;
                    upd_next        = 1'b1;
                    last_check_next = now_reg;
                    if (obstacle)
                    begin
                        case (phase_reg)
                            lfdc_pkg::PH_STOP:
                            begin
                                drv_next         = lfdc_pkg::DRV_STOP;
                                avoid_start_next = now_reg;
                                phase_next       = lfdc_pkg::PH_BACK;
                            end
                            lfdc_pkg::PH_BACK:
                            begin
                                drv_next = lfdc_pkg::DRV_BACK;
                                if (done_reg)
                                begin
                                    avoid_start_next = now_reg;
                                    phase_next       = lfdc_pkg::PH_SPIN;
                                end
                            end
                            lfdc_pkg::PH_SPIN:
                            begin
                                drv_next = lfdc_pkg::DRV_SPIN_R;
                                if (done_reg)
                                begin
                                    avoid_start_next = now_reg;
                                    phase_next       = lfdc_pkg::PH_FWD;
                                end
                            end
                            default:
                            begin
                                drv_next = lfdc_pkg::DRV_FWD;
                                if (done_reg)
                                begin
                                    phase_next = lfdc_pkg::PH_STOP;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        phase_next = lfdc_pkg::PH_STOP;
                        if (sens_reg[2] && sens_reg[1])
                        begin
                            drv_next = lfdc_pkg::DRV_FWD;
                        end
                        else if (!sens_reg[2] && sens_reg[1])
                        begin
                            drv_next = lfdc_pkg::DRV_SOFT_R;
                        end
                        else if (sens_reg[2] && !sens_reg[1])
                        begin
                            drv_next = lfdc_pkg::DRV_SOFT_L;
                        end
                        else if (!sens_reg[3])
                        begin
                            drv_next = lfdc_pkg::DRV_SPIN_R;
                        end
                        else if (!sens_reg[0])
                        begin
                            drv_next = lfdc_pkg::DRV_SPIN_L;
                        end
                        else
                        begin
                            drv_next = lfdc_pkg::DRV_STOP;
                        end
                    end
                end
            end
        end

        if (ctl.write && drv_en_reg)
        begin
            left_hold_next  = left_new;
            right_hold_next = right_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avoid_dist_reg <= lfdc_pkg::AVOID_DIST_RST;
            check_per_reg  <= lfdc_pkg::CHECK_PER_RST;
            back_time_reg  <= lfdc_pkg::BACK_TIME_RST;
            spin_time_reg  <= lfdc_pkg::SPIN_TIME_RST;
            fwd_time_reg   <= lfdc_pkg::FWD_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lfdc_pkg::CFG_AVOID_DIST: avoid_dist_reg <= cfg_data[9:0];
                lfdc_pkg::CFG_CHECK_PER:  check_per_reg  <= cfg_data;
                lfdc_pkg::CFG_BACK_TIME:  back_time_reg  <= cfg_data;
                lfdc_pkg::CFG_SPIN_TIME:  spin_time_reg  <= cfg_data;
                lfdc_pkg::CFG_FWD_TIME:   fwd_time_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= lfdc_pkg::LEVEL_RESET;
            auto_reg        <= 1'b1;
            manual_reg      <= lfdc_pkg::CH_S;
            last_check_reg  <= '0;
            phase_reg       <= lfdc_pkg::PH_STOP;
            avoid_start_reg <= '0;
            left_hold_reg   <= '0;
            right_hold_reg  <= '0;
            skip_reg        <= 1'b0;
            upd_reg         <= 1'b0;
            due_reg         <= 1'b0;
            done_reg        <= 1'b0;
            drv_en_reg      <= 1'b0;
            drv_reg         <= lfdc_pkg::DRV_STOP;
        end
        else
        begin
            level_reg       <= level_next;
            auto_reg        <= auto_next;
            manual_reg      <= manual_next;
            last_check_reg  <= last_check_next;
            phase_reg       <= phase_next;
            avoid_start_reg <= avoid_start_next;
            left_hold_reg   <= left_hold_next;
            right_hold_reg  <= right_hold_next;
            skip_reg        <= skip_next;
            upd_reg         <= upd_next;
            due_reg         <= due_next;
            done_reg        <= done_next;
            drv_en_reg      <= drv_en_next;
            drv_reg         <= drv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap)
        begin
            has_reg  <= has_command;
            cmd_reg  <= command_byte;
            now_reg  <= TB'(now_ms);
            sens_reg <= line_sensors;
            dist_reg <= distance_cm;
        end
        if (ctl.write)
        begin
            left_out_reg  <= drv_en_reg ? left_new : left_hold_reg;
            right_out_reg <= drv_en_reg ? right_new : right_hold_reg;
            upd_out_reg   <= upd_reg;
            auto_out_reg  <= auto_reg;
            level_out_reg <= level_reg;
        end
    end

    assign left_drive    = left_out_reg;
    assign right_drive   = right_out_reg;
    assign drive_updated = upd_out_reg;
    assign auto_mode     = auto_out_reg;
    assign speed_level   = level_out_reg;

endmodule
